### hdl/flc_pkg.sv
// shared types and fixed widths for the full linear convolution unit
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package flc_pkg;

  localparam int IDX_W   = 4;   // coefficient index field
  localparam int KLEN_W  = 5;   // kernel length register
  localparam int OUT_W   = 36;  // exact sum of products
  localparam int OUT_TDW = 40;  // output tdata, padded to bytes
  localparam int GRP     = 4;   // products summed per first-level adder

  localparam logic REQ_COEF   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // one sample issued into the tap line
  typedef struct packed {
    logic valid;  // a sample (real or flushed zero) enters this cycle
    logic clear;  // history returns to zeros instead of shifting
    logic last;   // final output of the whole convolution
  } issue_t;

endpackage

`default_nettype wire

### hdl/flc_coef_store.sv
// kernel coefficient registers, written by index from the input channel
// depends on flc_pkg
`default_nettype none

module flc_coef_store #(
  parameter int MAX_TAPS     = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   wr_en,
  input  wire logic [flc_pkg::IDX_W-1:0]              wr_idx,
  input  wire logic [SAMPLE_WIDTH-1:0]                wr_data,
  output logic      [MAX_TAPS-1:0][SAMPLE_WIDTH-1:0]  coef
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  logic [MAX_TAPS-1:0][SAMPLE_WIDTH-1:0] coef_r;
  logic [MAX_TAPS-1:0][SAMPLE_WIDTH-1:0] coef_nxt;
  logic                                  in_range;

  always_comb begin
    in_range = int'(wr_idx) < MAX_TAPS;
    coef_nxt = coef_r;
    if (wr_en && in_range) begin
      coef_nxt[AW'(wr_idx)] = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign coef = coef_r;

endmodule

`default_nettype wire

### hdl/flc_tap_products.sv
// sample history line and one registered multiplier per tap
// depends on flc_pkg
`default_nettype none

module flc_tap_products #(
  parameter int MAX_TAPS     = 16,
  parameter int SAMPLE_WIDTH = 16,
  parameter int LEN_W        = 5
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire flc_pkg::issue_t                           issue,
  input  wire logic [SAMPLE_WIDTH-1:0]                   sample,
  input  wire logic [LEN_W-1:0]                          len,
  input  wire logic [MAX_TAPS-1:0][SAMPLE_WIDTH-1:0]     coef,
  input  wire logic                                      down_ready,
  output logic                                           issue_ready,
  output logic                                           prod_valid,
  output logic                                           prod_last,
  output logic      [MAX_TAPS-1:0][flc_pkg::OUT_W-1:0]   prod
);

  localparam int HW = MAX_TAPS - 1;
  localparam int PW = 2 * SAMPLE_WIDTH;

  logic [HW-1:0][SAMPLE_WIDTH-1:0]           hist_r, hist_nxt;
  logic [MAX_TAPS-1:0][SAMPLE_WIDTH-1:0]     win;
  logic [MAX_TAPS-1:0][flc_pkg::OUT_W-1:0]   prod_r, prod_nxt;
  logic                                      a_v_r, a_v_nxt;
  logic                                      a_last_r, a_last_nxt;
  logic                                      a_ld;

  assign a_ld        = !a_v_r || down_ready;
  assign issue_ready = a_ld;

  always_comb begin
    win[0] = sample;
    for (int j = 1; j < MAX_TAPS; j++) begin
      win[j] = hist_r[j-1];
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_TAPS; j++) begin
      logic signed [PW-1:0] p;
      p = $signed(coef[j]) * $signed(win[j]);
      if (LEN_W'(j) < len) begin
        prod_nxt[j] = flc_pkg::OUT_W'(p);
      end else begin
        prod_nxt[j] = '0;
      end
    end
  end

  always_comb begin
    hist_nxt   = hist_r;
    a_v_nxt    = a_v_r;
    a_last_nxt = a_last_r;
    if (a_ld) begin
      a_v_nxt    = issue.valid;
      a_last_nxt = issue.last;
      if (issue.valid) begin
        if (issue.clear) begin
          hist_nxt = '0;
        end else begin
          hist_nxt = win[HW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r   <= '0;
      a_v_r    <= 1'b0;
      a_last_r <= 1'b0;
    end else begin
      hist_r   <= hist_nxt;
      a_v_r    <= a_v_nxt;
      a_last_r <= a_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ld && issue.valid) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_valid = a_v_r;
  assign prod_last  = a_last_r;
  assign prod       = prod_r;

endmodule

`default_nettype wire

### hdl/flc_adder_tree.sv
// two-level registered adder tree: partial-sum register, then output register
// depends on flc_pkg
`default_nettype none

module flc_adder_tree #(
  parameter int MAX_TAPS = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     prod_valid,
  input  wire logic                                     prod_last,
  input  wire logic [MAX_TAPS-1:0][flc_pkg::OUT_W-1:0]  prod,
  output logic                                          prod_ready,
  output logic                                          out_valid,
  output logic                                          out_last,
  output logic      [flc_pkg::OUT_W-1:0]                out_sum,
  input  wire logic                                     out_ready
);

  localparam int GS = flc_pkg::GRP;
  localparam int NG = (MAX_TAPS + GS - 1) / GS;

  logic [NG*GS-1:0][flc_pkg::OUT_W-1:0] pad;
  logic [NG-1:0][flc_pkg::OUT_W-1:0]    part_r, part_nxt;
  logic                                 b_v_r, b_v_nxt, b_last_r, b_last_nxt;
  logic                                 c_v_r, c_v_nxt, c_last_r, c_last_nxt;
  logic [flc_pkg::OUT_W-1:0]            sum_r, sum_nxt;
  logic                                 b_ld, c_ld;

  assign c_ld       = !c_v_r || out_ready;
  assign b_ld       = !b_v_r || c_ld;
  assign prod_ready = b_ld;

  always_comb begin
    pad = '0;
    pad[MAX_TAPS-1:0] = prod;
    for (int g = 0; g < NG; g++) begin
      part_nxt[g] = '0;
      for (int k = 0; k < GS; k++) begin
        part_nxt[g] = part_nxt[g] + pad[g*GS+k];
      end
    end
    sum_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      sum_nxt = sum_nxt + part_r[g];
    end
  end

  always_comb begin
    b_v_nxt    = b_ld ? prod_valid : b_v_r;
    b_last_nxt = b_ld ? prod_last  : b_last_r;
    c_v_nxt    = c_ld ? b_v_r      : c_v_r;
    c_last_nxt = c_ld ? b_last_r   : c_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r    <= 1'b0;
      b_last_r <= 1'b0;
      c_v_r    <= 1'b0;
      c_last_r <= 1'b0;
    end else begin
      b_v_r    <= b_v_nxt;
      b_last_r <= b_last_nxt;
      c_v_r    <= c_v_nxt;
      c_last_r <= c_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ld && prod_valid) begin
      part_r <= part_nxt;
    end
    if (c_ld && b_v_r) begin
      sum_r <= sum_nxt;
    end
  end

  assign out_valid = c_v_r;
  assign out_last  = c_last_r;
  assign out_sum   = sum_r;

endmodule

`default_nettype wire

### hdl/full_linear_convolution_unit.sv
// top level of the streaming full linear convolution unit
// depends on flc_pkg, flc_coef_store, flc_tap_products, flc_adder_tree
//
// usage: the in_ stream carries two kinds of word, picked by in_tuser. a
// coefficient word (tuser 0) writes the kernel position in tdata[3:0] and
// gives no output. a sample word (tuser 1) shifts into the history line and
// gives one exact sum of products on the out_ stream. a sample word with
// in_tlast also pushes kernel_len-1 zero samples through the line, one per
// cycle unless stalled, gives one output for each, raises out_tlast
// on the very last one and leaves the history at zero. cfg_we/cfg_wdata
// set kernel_len, which the user must write only while the block is idle
// (not enforced by the block); 0 acts as 1 and values above MAX_TAPS as
// MAX_TAPS. an accepted sample word passes through the product,
// partial-sum and output registers, the last of which drives out_tvalid.
// throughput is one word per cycle while out_tready is high; a last sample
// holds in_tready low during the tail flush. reset clears kernel, history
// and the pipeline and sets kernel_len to 1. when out_tready is low the
// pipeline fills its free stages, then drops in_tready; nothing is lost.
`default_nettype none

module full_linear_convolution_unit #(
  parameter int MAX_TAPS     = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [flc_pkg::KLEN_W-1:0]    cfg_wdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // coef_index [3:0], value [SAMPLE_WIDTH+3:4], zero pad above
  input  wire logic [((flc_pkg::IDX_W+SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  // req_type
  input  wire logic                          in_tuser,
  input  wire logic                          in_tlast,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // conv_out [35:0], zero pad [39:36]
  output logic [flc_pkg::OUT_TDW-1:0]        out_tdata,
  output logic                               out_tlast
);

  localparam int LEN_W = $clog2(MAX_TAPS + 1);
  localparam int SW    = SAMPLE_WIDTH;
  localparam int IW    = flc_pkg::IDX_W;

  logic [LEN_W-1:0]                  len_r, len_nxt;
  logic                              flush_r, flush_nxt;
  logic [LEN_W-1:0]                  cnt_r, cnt_nxt;
  logic                              issue_ready;
  logic                              in_acc;
  logic [IW-1:0]                     coef_index;
  logic [SW-1:0]                     value;
  logic [SW-1:0]                     sample;
  flc_pkg::issue_t                   issue;
  logic [MAX_TAPS-1:0][SW-1:0]       coef;
  logic                              prod_valid, prod_last, prod_ready;
  logic [MAX_TAPS-1:0][flc_pkg::OUT_W-1:0] prod;
  logic [flc_pkg::OUT_W-1:0]         out_sum;

  assign coef_index = in_tdata[IW-1:0];
  assign value      = in_tdata[IW+SW-1:IW];
  assign in_tready  = issue_ready && !flush_r;
  assign in_acc     = in_tvalid && in_tready;

  always_comb begin
    len_nxt = len_r;
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        len_nxt = LEN_W'(1);
      end else if (int'(cfg_wdata) > MAX_TAPS) begin
        len_nxt = LEN_W'(MAX_TAPS);
      end else begin
        len_nxt = LEN_W'(cfg_wdata);
      end
    end
  end

  always_comb begin
    issue     = '0;
    sample    = '0;
    flush_nxt = flush_r;
    cnt_nxt   = cnt_r;
    if (flush_r) begin
      if (issue_ready) begin
        issue.valid = 1'b1;
        if (cnt_r == LEN_W'(1)) begin
          issue.clear = 1'b1;
          issue.last  = 1'b1;
          flush_nxt   = 1'b0;
        end
        cnt_nxt = cnt_r - LEN_W'(1);
      end
    end else if (in_acc && in_tuser == flc_pkg::REQ_SAMPLE) begin
      issue.valid = 1'b1;
      sample      = value;
      if (in_tlast) begin
        if (len_r == LEN_W'(1)) begin
          issue.clear = 1'b1;
          issue.last  = 1'b1;
        end else begin
          flush_nxt = 1'b1;
          cnt_nxt   = len_r - LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= LEN_W'(1);
      flush_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      len_r   <= len_nxt;
      flush_r <= flush_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  flc_coef_store #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SW)
  ) u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc && in_tuser == flc_pkg::REQ_COEF),
    .wr_idx  (coef_index),
    .wr_data (value),
    .coef    (coef)
  );

  flc_tap_products #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SW),
    .LEN_W        (LEN_W)
  ) u_taps (
    .clk         (clk),
    .rst_n       (rst_n),
    .issue       (issue),
    .sample      (sample),
    .len         (len_r),
    .coef        (coef),
    .down_ready  (prod_ready),
    .issue_ready (issue_ready),
    .prod_valid  (prod_valid),
    .prod_last   (prod_last),
    .prod        (prod)
  );

  flc_adder_tree #(
    .MAX_TAPS (MAX_TAPS)
  ) u_tree (
    .clk        (clk),
    .rst_n      (rst_n),
    .prod_valid (prod_valid),
    .prod_last  (prod_last),
    .prod       (prod),
    .prod_ready (prod_ready),
    .out_valid  (out_tvalid),
    .out_last   (out_tlast),
    .out_sum    (out_sum),
    .out_ready  (out_tready)
  );

  assign out_tdata = {{(flc_pkg::OUT_TDW - flc_pkg::OUT_W){1'b0}}, out_sum};

  // no new word is taken while the tail is being flushed
  a_no_accept_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> !in_tready)
    else $error("input accepted during tail flush");

  a_flush_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> cnt_r != '0)
    else $error("flush active with zero count");

  a_final_ends_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (issue.valid && issue.last) |=> !flush_r)
    else $error("flush still active after final word");

  a_flush_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (flush_r && !(issue.valid && issue.last)) |=> flush_r)
    else $error("flush stopped before final word");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    issue.last |-> (issue.valid && issue.clear))
    else $error("final word issued without clearing history");

endmodule

`default_nettype wire
